FILE: design/gdct_pkg.sv
`default_nettype none

package gdct_pkg;

    // Sizing of the tracked pad
    localparam int NUM_AXES        = 6;
    localparam int NUM_BUTTONS     = 16;
    localparam int AXIS_BIT_OFFSET = 16;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 4;
    localparam int VALUE_W  = 16;
    localparam int DZ_W     = 15;
    localparam int MASK_W   = 32;
    localparam int MASK_IDX_W = $clog2(MASK_W);

    // Configuration registers: one deadzone per axis with a register
    localparam int NUM_DZ_REGS = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int DZ_IDX_W    = (NUM_DZ_REGS > 1) ? $clog2(NUM_DZ_REGS) : 1;

    localparam int AXIS_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int BTN_IDX_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Command codes of a request
    localparam logic [CMD_W-1:0] CMD_AXIS_EVENT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BTN_EVENT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_AXIS_LOAD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BTN_LOAD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LINK       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNLINK     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_POLL       = 3'd6;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_AXIS_EVENT,
        OP_BTN_EVENT,
        OP_AXIS_LOAD,
        OP_BTN_LOAD,
        OP_LINK,
        OP_UNLINK,
        OP_POLL
    } t_op_kind;

    // Classified request as it travels from front to back
    typedef struct packed {
        t_op_kind                   kind;
        logic [IDX_W-1:0]           index;
        logic signed [VALUE_W-1:0]  value;
        logic                       pressed;
    } t_op;

endpackage

`default_nettype wire

FILE: design/gdct_if.sv
`default_nettype none

interface gdct_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [3:0]  index;
    logic signed [15:0] axis_value;
    logic        button_pressed;

    modport source (output valid, command, index, axis_value, button_pressed, input ready);
    modport sink   (input valid, command, index, axis_value, button_pressed, output ready);
endinterface

interface gdct_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] changed_mask;

    modport source (output valid, changed_mask, input ready);
    modport sink   (input valid, changed_mask, output ready);
endinterface

interface gdct_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [14:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

FILE: design/gamepad_deadzone_change_tracker.sv
// Gamepad change tracker: keeps the last value of six analog axes and sixteen
// buttons and a 32-bit change mask (bits 0..15 buttons, bits 16..21 axes).
// Axis events pass the per-axis deadzone (a reading strictly inside plus or
// minus the deadzone becomes zero) and set the axis change bit when the result
// differs from the stored value; button events set the button bit when the
// state differs. Load requests write raw values with no change bit. Link sets
// connected and all mask bits, unlink clears both. Poll is the only request
// that returns a result: the mask, which it then clears, or zero with the mask
// kept while disconnected. Axis and button requests with an index out of
// range, and command 7 requests, are dropped. Throughput is one request per
// clock while the queue is not full: the front classifies a request and
// applies the deadzone in the cycle it is accepted, a two-entry queue holds
// it, and the back executes one per cycle unless a poll waits. A poll result
// passes through the queue, then the output register; the back waits only
// when a poll meets an untaken result; input ready drops only once the queue
// is full. Deadzones are written via the always-ready configuration port; the
// user must write them only while idle, and the block does not enforce it.
`default_nettype none

module gamepad_deadzone_change_tracker
    import gdct_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    gdct_item_if.sink     i_item,
    gdct_cfg_if.sink      i_cfg,
    gdct_result_if.source o_result
);

    t_op  push_op;
    logic push_valid;
    logic push_ready;
    t_op  head_op;
    logic head_valid;
    logic pop;

    // Classify requests, apply deadzones, hold configuration
    gdct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg        (i_cfg),
        .o_push_op    (push_op),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready)
    );

    // Decouple front from back so each side can stall on its own
    gdct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_op    (push_op),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_head_op    (head_op),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    // Update stores and mask, drive poll results
    gdct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_op    (head_op),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

FILE: design/gdct_front.sv
`default_nettype none

module gdct_front
    import gdct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gdct_item_if.sink i_item,
    gdct_cfg_if.sink  i_cfg,
    output t_op       o_push_op,
    output logic      o_push_valid,
    input  wire logic i_push_ready
);

    logic [DZ_W-1:0] r_dz [NUM_DZ_REGS];

    logic                      axis_ok;
    logic                      btn_ok;
    logic [DZ_W-1:0]           dz;
    logic signed [VALUE_W:0]   v_ext;
    logic signed [VALUE_W:0]   dz_ext;
    logic                      in_zone;
    logic signed [VALUE_W-1:0] dz_value;
    logic                      keep;
    t_op                       op;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DZ_REGS; i++) begin
                r_dz[i] <= '0;
            end
        end else if (i_cfg.valid && ({1'b0, i_cfg.reg_index} < (CFG_IDX_W+1)'(NUM_DZ_REGS))) begin
            r_dz[i_cfg.reg_index[DZ_IDX_W-1:0]] <= i_cfg.wr_data;
        end
    end

    always_comb begin
        axis_ok = ({1'b0, i_item.index} < (IDX_W+1)'(NUM_AXES));
        btn_ok  = ({1'b0, i_item.index} < (IDX_W+1)'(NUM_BUTTONS));

        // axes without a register get no deadzone
        if ({1'b0, i_item.index} < (IDX_W+1)'(NUM_DZ_REGS)) begin
            dz = r_dz[i_item.index[DZ_IDX_W-1:0]];
        end else begin
            dz = '0;
        end

        v_ext    = {i_item.axis_value[VALUE_W-1], i_item.axis_value};
        dz_ext   = {2'b00, dz};
        in_zone  = (v_ext > -dz_ext) && (v_ext < dz_ext);
        dz_value = in_zone ? '0 : i_item.axis_value;

        op.index   = i_item.index;
        op.value   = i_item.axis_value;
        op.pressed = i_item.button_pressed;
        op.kind    = OP_POLL;
        keep       = 1'b0;

        unique case (i_item.command)
            CMD_AXIS_EVENT: begin
                op.kind  = OP_AXIS_EVENT;
                op.value = dz_value;
                keep     = axis_ok;
            end
            CMD_BTN_EVENT: begin
                op.kind = OP_BTN_EVENT;
                keep    = btn_ok;
            end
            CMD_AXIS_LOAD: begin
                op.kind = OP_AXIS_LOAD;
                keep    = axis_ok;
            end
            CMD_BTN_LOAD: begin
                op.kind = OP_BTN_LOAD;
                keep    = btn_ok;
            end
            CMD_LINK: begin
                op.kind = OP_LINK;
                keep    = 1'b1;
            end
            CMD_UNLINK: begin
                op.kind = OP_UNLINK;
                keep    = 1'b1;
            end
            CMD_POLL: begin
                op.kind = OP_POLL;
                keep    = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // drop out-of-range and unknown requests; they never reach the queue
    assign i_item.ready = i_push_ready;
    assign o_push_valid = i_item.valid && keep;
    assign o_push_op    = op;

endmodule

`default_nettype wire

FILE: design/gdct_queue.sv
`default_nettype none

module gdct_queue
    import gdct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_op  i_push_op,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    output t_op       o_head_op,
    output logic      o_head_valid,
    input  wire logic i_pop
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_op    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/gdct_back.sv
`default_nettype none

module gdct_back
    import gdct_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_op     i_head_op,
    input  wire logic    i_head_valid,
    output logic         o_pop,
    gdct_result_if.source o_result
);

    logic signed [VALUE_W-1:0] r_axis [NUM_AXES];
    logic [NUM_BUTTONS-1:0]    r_btn;
    logic [MASK_W-1:0]         r_flags;
    logic                      r_connected;
    logic                      r_out_valid;
    logic [MASK_W-1:0]         r_mask;

    logic signed [VALUE_W-1:0] n_axis [NUM_AXES];
    logic [NUM_BUTTONS-1:0]    n_btn;
    logic [MASK_W-1:0]         n_flags;
    logic                      n_connected;

    logic                  stall;
    logic                  pop;
    logic                  is_poll;
    logic [AXIS_IDX_W-1:0] ai;
    logic [BTN_IDX_W-1:0]  bi;
    logic [MASK_IDX_W-1:0] axis_bit;
    logic [MASK_IDX_W-1:0] btn_bit;

    // a poll waits only while the output register holds an untaken result
    assign is_poll = (i_head_op.kind == OP_POLL);
    assign stall   = i_head_valid && is_poll && r_out_valid && !o_result.ready;
    assign pop     = i_head_valid && !stall;
    assign o_pop   = pop;

    assign ai       = i_head_op.index[AXIS_IDX_W-1:0];
    assign bi       = i_head_op.index[BTN_IDX_W-1:0];
    assign axis_bit = MASK_IDX_W'(AXIS_BIT_OFFSET) + MASK_IDX_W'(i_head_op.index);
    assign btn_bit  = MASK_IDX_W'(i_head_op.index);

    always_comb begin
        n_axis      = r_axis;
        n_btn       = r_btn;
        n_flags     = r_flags;
        n_connected = r_connected;

        if (pop) begin
            unique case (i_head_op.kind)
                OP_AXIS_EVENT: begin
                    if (r_axis[ai] != i_head_op.value) begin
                        n_flags[axis_bit] = 1'b1;
                        n_axis[ai]        = i_head_op.value;
                    end
                end
                OP_BTN_EVENT: begin
                    if (r_btn[bi] != i_head_op.pressed) begin
                        n_flags[btn_bit] = 1'b1;
                    end
                    n_btn[bi] = i_head_op.pressed;
                end
                OP_AXIS_LOAD: begin
                    n_axis[ai] = i_head_op.value;
                end
                OP_BTN_LOAD: begin
                    n_btn[bi] = i_head_op.pressed;
                end
                OP_LINK: begin
                    n_connected = 1'b1;
                    n_flags     = '1;
                end
                OP_UNLINK: begin
                    n_connected = 1'b0;
                    n_flags     = '0;
                end
                OP_POLL: begin
                    if (r_connected) begin
                        n_flags = '0;
                    end
                end
                default: begin
                    n_flags = r_flags;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_axis[i] <= '0;
            end
            r_btn       <= '0;
            r_flags     <= '0;
            r_connected <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_axis      <= n_axis;
            r_btn       <= n_btn;
            r_flags     <= n_flags;
            r_connected <= n_connected;
            if (pop && is_poll) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && is_poll) begin
            r_mask <= r_connected ? r_flags : '0;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.changed_mask = r_mask;

    a_unlink_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && (i_head_op.kind == OP_UNLINK) |=> !r_connected && (r_flags == '0))
        else $error("unlink did not clear connection and flags");

    a_link_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && (i_head_op.kind == OP_LINK) |=> r_connected && (r_flags == '1))
        else $error("link did not set connection and all flags");

    a_poll_disconnected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && is_poll && !r_connected |=> r_out_valid && (r_mask == '0)
            && (r_flags == $past(r_flags)))
        else $error("poll while disconnected returned data or dropped flags");

    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && is_poll && r_connected |=> r_out_valid && (r_flags == '0)
            && (r_mask == $past(r_flags)))
        else $error("poll while connected did not hand over and clear flags");

endmodule

`default_nettype wire

FILE: tb/gdct_mask_checker.sv
`timescale 1ns / 1ps

module gdct_mask_checker
    import gdct_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  logic                      i_item_ready,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [VALUE_W-1:0] i_axis_value,
    input  logic                      i_button_pressed,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DZ_W-1:0]           i_cfg_data,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  logic [MASK_W-1:0]         i_changed_mask,
    output int                        o_fail_count,
    output int                        o_pending
);

    logic [DZ_W-1:0]           deadzone   [NUM_DZ_REGS];
    logic signed [VALUE_W-1:0] axis_last  [NUM_AXES];
    logic                      button_last[NUM_BUTTONS];
    logic [MASK_W-1:0]         change_mask;
    logic                      linked;
    logic [MASK_W-1:0]         poll_masks [$];

    always @(posedge i_clk) begin : track_pad
        int                reading;
        int                zone;
        logic [MASK_W-1:0] wanted;
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_DZ_REGS; a++) deadzone[a] = '0;
            for (int a = 0; a < NUM_AXES; a++) axis_last[a] = '0;
            for (int b = 0; b < NUM_BUTTONS; b++) button_last[b] = 1'b0;
            change_mask = '0;
            linked      = 1'b0;
            poll_masks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_DZ_REGS)
                deadzone[i_cfg_index] = i_cfg_data;

            // retire the oldest poll before queueing a new one
            if (i_res_valid && i_res_ready) begin
                if (poll_masks.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %08h",
                             $time, i_changed_mask);
                    o_fail_count++;
                end else begin
                    wanted = poll_masks.pop_front();
                    if (i_changed_mask !== wanted) begin
                        $display("%0t: changed_mask mismatch, expected %08h, actual %08h",
                                 $time, wanted, i_changed_mask);
                        o_fail_count++;
                    end
                end
            end

            if (i_item_valid && i_item_ready) begin
                case (i_command)
                    CMD_AXIS_EVENT: if (i_index < NUM_AXES) begin
                        reading = i_axis_value;
                        zone    = (i_index < NUM_DZ_REGS) ? int'(deadzone[i_index]) : 0;
                        if (reading > -zone && reading < zone)
                            reading = 0;
                        if (int'(axis_last[i_index]) != reading) begin
                            change_mask[AXIS_BIT_OFFSET + i_index] = 1'b1;
                            axis_last[i_index] = VALUE_W'(reading);
                        end
                    end
                    CMD_BTN_EVENT: if (i_index < NUM_BUTTONS) begin
                        if (button_last[i_index] != i_button_pressed)
                            change_mask[i_index] = 1'b1;
                        button_last[i_index] = i_button_pressed;
                    end
                    CMD_AXIS_LOAD: if (i_index < NUM_AXES)
                        axis_last[i_index] = i_axis_value;
                    CMD_BTN_LOAD: if (i_index < NUM_BUTTONS)
                        button_last[i_index] = i_button_pressed;
                    CMD_LINK: begin
                        linked      = 1'b1;
                        change_mask = '1;
                    end
                    CMD_UNLINK: begin
                        linked      = 1'b0;
                        change_mask = '0;
                    end
                    CMD_POLL: begin
                        if (linked) begin
                            poll_masks.push_back(change_mask);
                            change_mask = '0;
                        end else begin
                            poll_masks.push_back('0);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending = poll_masks.size();
    end

endmodule

FILE: tb/tb_gamepad_deadzone_change_tracker.sv
`timescale 1ns / 1ps

module tb_gamepad_deadzone_change_tracker;
    import gdct_pkg::*;

    // Command 7 has no meaning; the block must drop it
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

    // Cycles without any request or result moving before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // Drain time after the last poll result, with margin for the queue and back end
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 250;

    logic i_clk;
    logic i_rst_n;
    logic calm;            // suppress idling on both sides
    int   fail_count;
    int   pending;
    int   stall_cycles = 0;
    int   zone_cfg [NUM_DZ_REGS];

    gdct_item_if   item_if ();
    gdct_cfg_if    cfg_if ();
    gdct_result_if res_if ();

    gamepad_deadzone_change_tracker DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    gdct_mask_checker u_mask_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_if.valid),
        .i_item_ready     (item_if.ready),
        .i_command        (item_if.command),
        .i_index          (item_if.index),
        .i_axis_value     (item_if.axis_value),
        .i_button_pressed (item_if.button_pressed),
        .i_cfg_valid      (cfg_if.valid),
        .i_cfg_ready      (cfg_if.ready),
        .i_cfg_index      (cfg_if.reg_index),
        .i_cfg_data       (cfg_if.wr_data),
        .i_res_valid      (res_if.valid),
        .i_res_ready      (res_if.ready),
        .i_changed_mask   (res_if.changed_mask),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: stall about a third of the time unless the calm stretch is on
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= calm || ($urandom_range(99) >= 35);
        end
    end

    // Offer one request, with random idle cycles ahead of it. Entered and left at a
    // falling edge; valid stays high on exit so back-to-back requests need no dip.
    task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic signed [VALUE_W-1:0] val, input logic pressed);
        while (!calm && $urandom_range(99) < 35) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid          <= 1'b1;
        item_if.command        <= cmd;
        item_if.index          <= idx;
        item_if.axis_value     <= val;
        item_if.button_pressed <= pressed;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write every register index, the deadzones from zone_cfg and junk into the
    // two indexes that have no register behind them.
    task automatic apply_zones();
        for (int r = 0; r < 8; r++) begin
            cfg_if.valid     <= 1'b1;
            cfg_if.reg_index <= CFG_IDX_W'(r);
            cfg_if.wr_data   <= (r < NUM_DZ_REGS) ? DZ_W'(zone_cfg[r]) : DZ_W'($urandom);
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Hold the sender until every poll has answered, then let the queue drain
    task automatic settle();
        item_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed events around the current deadzones, plus some noise
    task automatic random_request();
        int                        pick;
        int                        zone;
        int                        level;
        logic [CMD_W-1:0]          cmd;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] val;
        pick = $urandom_range(99);
        if      (pick < 30) cmd = CMD_AXIS_EVENT;
        else if (pick < 50) cmd = CMD_BTN_EVENT;
        else if (pick < 58) cmd = CMD_AXIS_LOAD;
        else if (pick < 65) cmd = CMD_BTN_LOAD;
        else if (pick < 70) cmd = CMD_LINK;
        else if (pick < 73) cmd = CMD_UNLINK;
        else if (pick < 97) cmd = CMD_POLL;
        else                cmd = CMD_SPARE;

        // occasionally aim past the last axis
        if ($urandom_range(9) == 0)
            idx = IDX_W'($urandom_range(15));
        else if (cmd == CMD_AXIS_EVENT || cmd == CMD_AXIS_LOAD)
            idx = IDX_W'($urandom_range(NUM_AXES - 1));
        else
            idx = IDX_W'($urandom_range(NUM_BUTTONS - 1));

        zone = (idx < NUM_DZ_REGS) ? zone_cfg[idx] : 0;
        case ($urandom_range(3))
            0: val = VALUE_W'($urandom);
            1: begin
                // just below, on, or just above the deadzone edge, either sign
                level = zone + int'($urandom_range(2)) - 1;
                if ($urandom_range(1) == 1) level = -level;
                val = VALUE_W'(level);
            end
            2: val = VALUE_W'(int'($urandom_range(2 * zone)) - zone);
            default: begin
                pick = $urandom_range(2);
                val  = (pick == 0) ? 16'sh7FFF : (pick == 1) ? 16'sh8000 : 16'sh0000;
            end
        endcase
        push_request(cmd, idx, val, 1'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n                = 1'b0;
        calm                   = 1'b0;
        item_if.valid          = 1'b0;
        item_if.command        = '0;
        item_if.index          = '0;
        item_if.axis_value     = '0;
        item_if.button_pressed = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.reg_index       = '0;
        cfg_if.wr_data         = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero and full-scale deadzones, tiny and mid ones
        zone_cfg = '{0, 32767, 100, 1, 16384, 500};
        apply_zones();

        push_request(CMD_POLL,       4'd0,  16'sh0000, 1'b0);  // disconnected poll
        push_request(CMD_AXIS_EVENT, 4'd0,  16'sh8000, 1'b0);  // no deadzone, most negative
        push_request(CMD_BTN_EVENT,  4'd15, 16'sh0000, 1'b1);
        push_request(CMD_POLL,       4'd0,  16'sh0000, 1'b0);  // still zero, mask kept
        push_request(CMD_LINK,       4'd0,  16'sh0000, 1'b0);
        push_request(CMD_POLL,       4'd0,  16'sh0000, 1'b0);  // all ones
        push_request(CMD_AXIS_EVENT, 4'd1,  16'sh7FFF, 1'b0);  // exactly on the edge
        push_request(CMD_AXIS_EVENT, 4'd1,  16'sh8001, 1'b0);  // negative edge
        push_request(CMD_AXIS_EVENT, 4'd1,  16'sh0005, 1'b0);  // inside, becomes zero
        push_request(CMD_AXIS_EVENT, 4'd2,  16'sh0063, 1'b0);  // inside, same as stored
        push_request(CMD_AXIS_EVENT, 4'd3,  16'shFFFF, 1'b0);  // on the edge of one
        push_request(CMD_AXIS_EVENT, 4'd6,  16'sh1234, 1'b0);  // past the last axis
        push_request(CMD_AXIS_EVENT, 4'd15, 16'sh7FFF, 1'b0);
        push_request(CMD_BTN_EVENT,  4'd15, 16'sh0000, 1'b1);  // same state
        push_request(CMD_BTN_EVENT,  4'd0,  16'sh0000, 1'b1);
        push_request(CMD_AXIS_LOAD,  4'd4,  16'sh3039, 1'b0);
        push_request(CMD_BTN_LOAD,   4'd3,  16'sh0000, 1'b1);
        push_request(CMD_AXIS_LOAD,  4'd9,  16'sh5555, 1'b0);  // past the last axis
        push_request(CMD_SPARE,      4'd2,  16'shAAAA, 1'b1);
        push_request(CMD_POLL,       4'd0,  16'sh0000, 1'b0);
        push_request(CMD_UNLINK,     4'd0,  16'sh0000, 1'b0);
        push_request(CMD_BTN_EVENT,  4'd3,  16'sh0000, 1'b0);  // change while unlinked
        push_request(CMD_POLL,       4'd0,  16'sh0000, 1'b0);
        push_request(CMD_LINK,       4'd0,  16'sh0000, 1'b0);
        push_request(CMD_POLL,       4'd0,  16'sh0000, 1'b0);
        settle();

        // Random phases, each under its own deadzones; the first two are the extremes
        for (int phase = 0; phase < PHASES; phase++) begin
            for (int a = 0; a < NUM_DZ_REGS; a++) begin
                if (phase == 0)
                    zone_cfg[a] = 0;
                else if (phase == 1)
                    zone_cfg[a] = 32767;
                else if ($urandom_range(3) == 0)
                    zone_cfg[a] = $urandom_range(32767);
                else
                    zone_cfg[a] = $urandom_range(2000);
            end
            calm = (phase == 3);
            apply_zones();
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request();
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
